// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; rbap_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, except while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check a property on every rising edge of clk, including reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/rbap_pkg.sv
package rbap_pkg;

  localparam int MAX_DISKS = 8;
  localparam int DISK_W    = $clog2(MAX_DISKS);
  localparam int PAIRS     = MAX_DISKS / 2;
  localparam int PAIR_W    = $clog2(PAIRS);
  localparam int BLK_W     = 32;
  localparam int ND_W      = 4;
  localparam int CAP_W     = BLK_W + ND_W;
  localparam int STEP_W    = $clog2(MAX_DISKS + 2);
  localparam int DCNT_W    = $clog2(BLK_W + 1);

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_READ_XOR  = 3'd1,
    ACT_WRITE     = 3'd2,
    ACT_ACC_XOR   = 3'd3,
    ACT_WRITE_ACC = 3'd4,
    ACT_NONE      = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DISK  = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_HEALTH = 2'd2;

  localparam logic [2:0] LVL_R0  = 3'd0;
  localparam logic [2:0] LVL_R1  = 3'd1;
  localparam logic [2:0] LVL_R01 = 3'd2;
  localparam logic [2:0] LVL_R4  = 3'd3;
  localparam logic [2:0] LVL_R5  = 3'd4;

  localparam logic [1:0] CFG_RAID_LEVEL = 2'd0;
  localparam logic [1:0] CFG_DISKS      = 2'd1;
  localparam logic [1:0] CFG_BPD        = 2'd2;

  localparam logic [1:0] HEALTH_OK    = 2'd0;
  localparam logic [1:0] HEALTH_UNREC = 2'd2;
  localparam logic [1:0] HEALTH_BAD3  = 2'd3;

  localparam logic [BLK_W-1:0] BPD_RESET = BLK_W'(65536);
  localparam logic [ND_W-1:0]  ND_RESET  = ND_W'(8);

  typedef enum logic [2:0] {
    M_ONE     = 3'd0,
    M_MW2     = 3'd1,
    M_RMW     = 3'd2,
    M_SCAN_RD = 3'd3,
    M_SCAN_WR = 3'd4
  } mode_t;

  typedef struct packed {
    logic capture;
    logic calc_cap;
    logic check;
    logic div1_start;
    logic div2_start;
    logic plan;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic go_div;
    logic is_r5;
    logic div_done;
    logic emit_valid;
    logic emit_last;
  } dp_sts_t;

endpackage

// File: rtl/rbap_chan_if.sv
interface rbap_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] logical_block;
  logic [2:0]  target_member;
  logic [1:0]  new_health;

  modport source(output valid, opcode, logical_block, target_member, new_health,
                 input ready);
  modport sink(input valid, opcode, logical_block, target_member, new_health,
               output ready);
endinterface

interface rbap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  member_disk;
  logic [31:0] member_block;
  logic [2:0]  action;
  logic [1:0]  status;
  logic        last;

  modport source(output valid, member_disk, member_block, action, status, last,
                 input ready);
  modport sink(input valid, member_disk, member_block, action, status, last,
               output ready);
endinterface

// File: rtl/rbap_div.sv
module rbap_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rbap_pkg::BLK_W-1:0] dividend,
  input  logic [rbap_pkg::BLK_W-1:0] divisor,
  output logic [rbap_pkg::BLK_W-1:0] quo,
  output logic [rbap_pkg::BLK_W-1:0] rem,
  output logic                     done
);

  localparam int W = rbap_pkg::BLK_W;

  logic [W-1:0]                  q_r, q_nxt, d_r, d_nxt, r_r, r_nxt;
  logic [rbap_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0]                    sh;
  logic [W+1:0]                  diff;

  always_comb begin
    sh       = {r_r, q_r[W-1]};
    diff     = {1'b0, sh} - {2'b00, d_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = rbap_pkg::DCNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: one quotient bit a cycle
      if (!diff[W+1]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = sh[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rbap_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = q_r;
  assign rem  = r_r;
  assign done = done_r;

endmodule

// File: rtl/rbap_dp.sv
module rbap_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [31:0]           cfg_data,
  input  logic [1:0]            opcode,
  input  logic [31:0]           logical_block,
  input  logic [2:0]            target_member,
  input  logic [1:0]            new_health,
  input  rbap_pkg::dp_cmd_t     cmd,
  output rbap_pkg::dp_sts_t     sts,
  output logic [2:0]            member_disk,
  output logic [31:0]           member_block,
  output logic [2:0]            action,
  output logic [1:0]            status,
  output logic                  last
);

  localparam int DW = rbap_pkg::DISK_W;
  localparam int BW = rbap_pkg::BLK_W;
  localparam int NW = rbap_pkg::ND_W;
  localparam int SW = rbap_pkg::STEP_W;

  // configuration
  logic [2:0]    lvl_r;
  logic [NW-1:0] ndi_r;
  logic [BW-1:0] bpd_r;

  // request
  logic [1:0]    op_r;
  logic [BW-1:0] lb_r;
  logic [DW-1:0] tm_r;
  logic [1:0]    nh_r;

  logic [rbap_pkg::CAP_W-1:0] cap_r;
  logic [1:0] health_r [rbap_pkg::MAX_DISKS];
  logic [rbap_pkg::PAIRS-1:0] turn1_r, turn01_r;
  logic [rbap_pkg::MAX_DISKS-1:0] h_ok;

  logic [NW-1:0] nd, half;
  logic [BW-1:0] per;

  // divider
  logic          div_start, div_done, phase2_r;
  logic [BW-1:0] div_a, div_b, div_q, div_r;
  logic [BW-1:0] q1_r, r1_r;

  // plan registers
  rbap_pkg::mode_t mode_r, p_mode;
  logic [DW-1:0] pl_disk_r, pl_disk2_r, p_disk, p_disk2;
  logic [BW-1:0] pl_blk_r, p_blk;
  rbap_pkg::act_t    pl_act_r, p_act;
  rbap_pkg::status_t pl_st_r, p_st;
  logic [NW-1:0] lasti_r, p_lasti;
  logic          first_r;
  logic [SW-1:0] step_r;

  // output register
  logic [DW-1:0] om_disk_r;
  logic [BW-1:0] om_blk_r;
  rbap_pkg::act_t    om_act_r;
  rbap_pkg::status_t om_st_r;
  logic          om_last_r;

  // emit
  logic          e_valid, e_last;
  logic [DW-1:0] e_disk;
  rbap_pkg::act_t e_act;
  logic          load;

  // check
  logic          go_div;
  rbap_pkg::status_t c_st;

  // plan helpers
  logic [BW-1:0] blk_sel, blk1, pair;
  logic [DW-1:0] d0, d1, tgt0, tgtp, par, tgt;
  logic          tb, ok0, ok1, oth_ok, turn_we, turn_val;
  logic [NW-1:0] nd_m1;

  always_comb begin
    nd = ndi_r;
    if (ndi_r == '0) nd = NW'(1);
    if (ndi_r > NW'(rbap_pkg::MAX_DISKS)) nd = NW'(rbap_pkg::MAX_DISKS);
    per   = (bpd_r >= BW'(2)) ? bpd_r - 1'b1 : '0;
    half  = nd >> 1;
    nd_m1 = nd - 1'b1;
    for (int i = 0; i < rbap_pkg::MAX_DISKS; i++) h_ok[i] = (health_r[i] == rbap_pkg::HEALTH_OK);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= rbap_pkg::LVL_R0;
      ndi_r <= rbap_pkg::ND_RESET;
      bpd_r <= rbap_pkg::BPD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        rbap_pkg::CFG_RAID_LEVEL: lvl_r <= cfg_data[2:0];
        rbap_pkg::CFG_DISKS:      ndi_r <= cfg_data[NW-1:0];
        rbap_pkg::CFG_BPD:        bpd_r <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= opcode;
      lb_r <= logical_block;
      tm_r <= target_member;
      nh_r <= new_health;
    end
    if (cmd.calc_cap) begin
      case (lvl_r)
        rbap_pkg::LVL_R0: cap_r <= rbap_pkg::CAP_W'(nd) * rbap_pkg::CAP_W'(per);
        rbap_pkg::LVL_R1, rbap_pkg::LVL_R01:
          cap_r <= rbap_pkg::CAP_W'(half) * rbap_pkg::CAP_W'(per);
        rbap_pkg::LVL_R4, rbap_pkg::LVL_R5:
          cap_r <= (nd >= NW'(2)) ? rbap_pkg::CAP_W'(nd_m1) * rbap_pkg::CAP_W'(per) : '0;
        default: cap_r <= '0;
      endcase
    end
  end

  // check stage: single-result answers, else the go-ahead to divide
  always_comb begin
    go_div = 1'b0;
    c_st   = rbap_pkg::ST_OK;
    if (op_r == rbap_pkg::OP_HEALTH) begin
      c_st = ({1'b0, tm_r} < nd) ? rbap_pkg::ST_OK : rbap_pkg::ST_RANGE;
    end else if (op_r == rbap_pkg::OP_READ || op_r == rbap_pkg::OP_WRITE) begin
      if (lvl_r > rbap_pkg::LVL_R5) c_st = rbap_pkg::ST_NO_DISK;
      else if ({{rbap_pkg::ND_W{1'b0}}, lb_r} >= cap_r) c_st = rbap_pkg::ST_RANGE;
      else go_div = 1'b1;
    end
  end

  // divider operands
  always_comb begin
    div_start = cmd.div1_start | cmd.div2_start;
    if (cmd.div2_start) begin
      div_a = div_q;
      div_b = BW'(nd);
    end else begin
      div_a = lb_r;
      case (lvl_r)
        rbap_pkg::LVL_R0:  div_b = BW'(nd);
        rbap_pkg::LVL_R1:  div_b = per;
        rbap_pkg::LVL_R01: div_b = BW'(half);
        default:           div_b = BW'(nd_m1);
      endcase
    end
  end

  rbap_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quo(div_q), .rem(div_r), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) phase2_r <= 1'b0;
    else if (cmd.div1_start) phase2_r <= 1'b0;
    else if (cmd.div2_start) phase2_r <= 1'b1;
    if (div_done && !phase2_r) begin
      q1_r <= div_q;
      r1_r <= div_r;
    end
  end

  // plan stage
  always_comb begin
    blk_sel = (lvl_r == rbap_pkg::LVL_R1) ? r1_r : q1_r;
    blk1    = blk_sel + 1'b1;
    pair    = (lvl_r == rbap_pkg::LVL_R1) ? q1_r : r1_r;
    d0      = pair[DW-1:0];
    d1      = pair[DW-1:0] + half[DW-1:0];
    tb      = (lvl_r == rbap_pkg::LVL_R1) ? turn1_r[pair[rbap_pkg::PAIR_W-1:0]]
                                          : turn01_r[pair[rbap_pkg::PAIR_W-1:0]];
    ok0     = h_ok[d0];
    ok1     = h_ok[d1];
    tgt0    = r1_r[DW-1:0];
    tgtp    = r1_r[DW-1:0];
    if (lvl_r == rbap_pkg::LVL_R5) par = DW'(nd_m1 - div_r[NW-1:0]);
    else                           par = nd_m1[DW-1:0];
    tgt = tgtp;
    if (lvl_r == rbap_pkg::LVL_R5 && par <= tgtp) tgt = tgtp + 1'b1;
    oth_ok = 1'b1;
    for (int i = 0; i < rbap_pkg::MAX_DISKS; i++)
      if (NW'(i) < nd && DW'(i) != tgt && !h_ok[i]) oth_ok = 1'b0;
    p_lasti = ({1'b0, tgt} == nd_m1) ? nd - NW'(2) : nd_m1;

    p_mode   = rbap_pkg::M_ONE;
    p_disk   = '0;
    p_disk2  = '0;
    p_blk    = blk1;
    p_act    = rbap_pkg::ACT_NONE;
    p_st     = rbap_pkg::ST_OK;
    turn_we  = 1'b0;
    turn_val = 1'b0;
    case (lvl_r)
      rbap_pkg::LVL_R0: begin
        if (h_ok[tgt0]) begin
          p_disk = tgt0;
          p_act  = (op_r == rbap_pkg::OP_WRITE) ? rbap_pkg::ACT_WRITE : rbap_pkg::ACT_READ;
        end else begin
          p_st = rbap_pkg::ST_NO_DISK;
        end
      end
      rbap_pkg::LVL_R1, rbap_pkg::LVL_R01: begin
        if (pair >= BW'(rbap_pkg::PAIRS)) begin
          p_st = rbap_pkg::ST_RANGE;
        end else if (op_r == rbap_pkg::OP_WRITE) begin
          if (ok0 && ok1) begin
            p_mode  = rbap_pkg::M_MW2;
            p_disk  = d0;
            p_disk2 = d1;
          end else if (ok0 || ok1) begin
            p_disk = ok0 ? d0 : d1;
            p_act  = rbap_pkg::ACT_WRITE;
          end else begin
            p_st = rbap_pkg::ST_NO_DISK;
          end
        end else begin
          if (ok0 || ok1) begin
            p_disk   = (ok0 && ok1) ? (tb ? d0 : d1) : (ok0 ? d0 : d1);
            p_act    = rbap_pkg::ACT_READ;
            turn_we  = 1'b1;
            turn_val = (p_disk != d0);
          end else begin
            p_st = rbap_pkg::ST_NO_DISK;
          end
        end
      end
      default: begin
        p_disk  = tgt;
        p_disk2 = par;
        if (op_r == rbap_pkg::OP_WRITE) begin
          if (h_ok[tgt]) begin
            if (h_ok[par]) p_mode = rbap_pkg::M_RMW;
            else p_act = rbap_pkg::ACT_WRITE;
          end else if (oth_ok) begin
            p_mode = rbap_pkg::M_SCAN_WR;
          end else begin
            p_st = rbap_pkg::ST_NO_DISK;
          end
        end else begin
          if (h_ok[tgt]) p_act = rbap_pkg::ACT_READ;
          else if (oth_ok) p_mode = rbap_pkg::M_SCAN_RD;
          else p_st = rbap_pkg::ST_NO_DISK;
        end
      end
    endcase
    // error answers carry disk 0 and block 0
    if (p_st != rbap_pkg::ST_OK) begin
      p_disk = '0;
      p_blk  = '0;
    end
  end

  // state: health and mirror turns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rbap_pkg::MAX_DISKS; i++) health_r[i] <= rbap_pkg::HEALTH_OK;
      turn1_r  <= '0;
      turn01_r <= '0;
    end else begin
      if (cmd.check && op_r == rbap_pkg::OP_HEALTH && {1'b0, tm_r} < nd)
        health_r[tm_r] <= (nh_r == rbap_pkg::HEALTH_BAD3) ? rbap_pkg::HEALTH_UNREC : nh_r;
      if (cmd.plan && turn_we) begin
        if (lvl_r == rbap_pkg::LVL_R1) turn1_r[pair[rbap_pkg::PAIR_W-1:0]] <= turn_val;
        else                           turn01_r[pair[rbap_pkg::PAIR_W-1:0]] <= turn_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rbap_pkg::M_ONE;
      step_r <= '0;
    end else if (cmd.check) begin
      mode_r <= rbap_pkg::M_ONE;
      step_r <= '0;
    end else if (cmd.plan) begin
      mode_r <= p_mode;
      step_r <= '0;
    end else if (cmd.step) begin
      step_r <= step_r + 1'b1;
    end
    if (cmd.check) begin
      pl_disk_r <= '0;
      pl_blk_r  <= '0;
      pl_act_r  <= rbap_pkg::ACT_NONE;
      pl_st_r   <= c_st;
    end else if (cmd.plan) begin
      pl_disk_r  <= p_disk;
      pl_disk2_r <= p_disk2;
      pl_blk_r   <= p_blk;
      pl_act_r   <= p_act;
      pl_st_r    <= p_st;
      lasti_r    <= p_lasti;
      first_r    <= 1'b1;
    end else if (load) begin
      first_r <= 1'b0;
    end
  end

  // command sequencer
  always_comb begin
    e_valid = 1'b0;
    e_last  = 1'b0;
    e_disk  = pl_disk_r;
    e_act   = pl_act_r;
    case (mode_r)
      rbap_pkg::M_ONE: begin
        e_valid = (step_r == '0);
        e_last  = 1'b1;
      end
      rbap_pkg::M_MW2: begin
        e_valid = (step_r < SW'(2));
        e_last  = (step_r == SW'(1));
        e_disk  = (step_r == '0) ? pl_disk_r : pl_disk2_r;
        e_act   = rbap_pkg::ACT_WRITE;
      end
      rbap_pkg::M_RMW: begin
        e_valid = (step_r < SW'(4));
        e_last  = (step_r == SW'(3));
        case (step_r)
          SW'(0):  begin e_disk = pl_disk_r;  e_act = rbap_pkg::ACT_ACC_XOR;   end
          SW'(1):  begin e_disk = pl_disk2_r; e_act = rbap_pkg::ACT_ACC_XOR;   end
          SW'(2):  begin e_disk = pl_disk2_r; e_act = rbap_pkg::ACT_WRITE_ACC; end
          default: begin e_disk = pl_disk_r;  e_act = rbap_pkg::ACT_WRITE;     end
        endcase
      end
      rbap_pkg::M_SCAN_RD: begin
        e_valid = (SW'(nd) > step_r) && (step_r != SW'(pl_disk_r));
        e_last  = (SW'(lasti_r) == step_r);
        e_disk  = step_r[DW-1:0];
        e_act   = first_r ? rbap_pkg::ACT_READ : rbap_pkg::ACT_READ_XOR;
      end
      rbap_pkg::M_SCAN_WR: begin
        if (SW'(nd) == step_r) begin
          e_valid = 1'b1;
          e_last  = 1'b1;
          e_disk  = pl_disk2_r;
          e_act   = rbap_pkg::ACT_WRITE_ACC;
        end else begin
          e_valid = (SW'(nd) > step_r) && (step_r != SW'(pl_disk_r))
                    && (step_r != SW'(pl_disk2_r));
          e_disk  = step_r[DW-1:0];
          e_act   = rbap_pkg::ACT_ACC_XOR;
        end
      end
      default: ;
    endcase
    load = cmd.step && e_valid;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      om_disk_r <= e_disk;
      om_blk_r  <= pl_blk_r;
      om_act_r  <= e_act;
      om_st_r   <= pl_st_r;
      om_last_r <= e_last;
    end
  end

  assign sts.go_div     = go_div;
  assign sts.is_r5      = (lvl_r == rbap_pkg::LVL_R5);
  assign sts.div_done   = div_done;
  assign sts.emit_valid = e_valid;
  assign sts.emit_last  = e_last;

  assign member_disk  = om_disk_r;
  assign member_block = om_blk_r;
  assign action       = om_act_r;
  assign status       = om_st_r;
  assign last         = om_last_r;

endmodule

// File: rtl/rbap_ctrl.sv
`include "assert_macros.svh"

module rbap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rbap_pkg::dp_cmd_t cmd,
  input  rbap_pkg::dp_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CAP   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV1  = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_PLAN  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt, slot_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    slot_free = !out_valid_r || out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CAP;
        end
      end
      S_CAP: begin
        cmd.calc_cap = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.go_div) begin
          cmd.div1_start = 1'b1;
          state_nxt      = S_DIV1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          if (sts.is_r5) begin
            cmd.div2_start = 1'b1;
            state_nxt      = S_DIV2;
          end else begin
            state_nxt = S_PLAN;
          end
        end
      end
      S_DIV2: begin
        if (sts.div_done) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // advance one command whenever the output slot can take a beat
        if (slot_free) begin
          cmd.step = 1'b1;
          if (sts.emit_valid && sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.step && sts.emit_valid) out_valid_nxt = 1'b1;
    else if (out_ready)             out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_no_overwrite, (cmd.step && sts.emit_valid) |-> (!out_valid_r || out_ready), "result beat overwritten")
  `ASSERT_CLK(a_last_to_idle, (cmd.step && sts.emit_valid && sts.emit_last) |=> (state_r == S_IDLE), "request not closed after last beat")
  `ASSERT_CLK(a_div_done_ctx, sts.div_done |-> (state_r == S_DIV1 || state_r == S_DIV2), "divider finished outside a divide state")

endmodule

// File: rtl/raid_block_access_planner.sv
// An answer that needs no mapping (health update, error found at the check) passes
// capture, check and emit; a mapped request adds a divide (two for RAID5) and a plan step.
// Throughput: one request at a time, set by the bit-serial divider, the sequencer
// steps (up to 9 steps) and output stalls.
// Reset (rst_n, synchronous): registers to RAID0, 8 disks, 65536 blocks,
// every disk healthy and all mirror turn bits cleared.
module raid_block_access_planner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  rbap_in_if.sink     in_if,
  rbap_out_if.source  out_if
);

  rbap_pkg::dp_cmd_t cmd;
  rbap_pkg::dp_sts_t sts;

  rbap_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .cmd(cmd), .sts(sts)
  );

  rbap_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .opcode(in_if.opcode), .logical_block(in_if.logical_block),
    .target_member(in_if.target_member), .new_health(in_if.new_health),
    .cmd(cmd), .sts(sts),
    .member_disk(out_if.member_disk), .member_block(out_if.member_block),
    .action(out_if.action), .status(out_if.status), .last(out_if.last)
  );

endmodule

// File: test/tb_raid_block_access_planner.sv
`timescale 1ns / 1ps

module tb_raid_block_access_planner;
  import rbap_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] lb;
    logic [2:0]  tm;
    logic [1:0]  nh;
  } req_t;

  typedef struct {
    logic [2:0]  disk;
    logic [31:0] blk;
    act_t        act;
    status_t     st;
    logic        last;
  } disk_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  rbap_in_if  in_if ();
  rbap_out_if out_if ();

  raid_block_access_planner dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_if(in_if), .out_if(out_if)
  );

  always #5 clk = ~clk;

  // mirror of the block's registers and state
  logic [2:0]  lvl_m;
  logic [3:0]  disks_m;
  logic [31:0] bpd_m;
  logic [1:0]  health_m [MAX_DISKS];
  logic        turn_r1_m [PAIRS];
  logic        turn_r01_m [PAIRS];

  req_t      req_q [$];
  disk_cmd_t cmd_q [$];
  disk_cmd_t plan_q [$];
  req_t      cur_req;
  int unsigned issued = 0, accepted = 0;
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;

  function automatic bit disk_ok(int d);
    return d < MAX_DISKS && health_m[d] == HEALTH_OK;
  endfunction

  function automatic bit rest_ok(int nd, int skip);
    for (int i = 0; i < nd; i++)
      if (i != skip && !disk_ok(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_cmd(int d, longint unsigned b, act_t a, status_t s);
    disk_cmd_t c;
    c.disk = d[2:0];
    c.blk = b[31:0];
    c.act = a;
    c.st = s;
    c.last = 1'b0;
    plan_q.push_back(c);
  endfunction

  function automatic int clamp_disks();
    if (disks_m == 0) return 1;
    if (disks_m > MAX_DISKS) return MAX_DISKS;
    return disks_m;
  endfunction

  function automatic void mirror_plan(bit wr, int d0, int d1, longint unsigned b, bit r1,
                                      int pair);
    bit ok0, ok1, t;
    int d;
    ok0 = disk_ok(d0);
    ok1 = disk_ok(d1);
    if (wr) begin
      if (ok0) add_cmd(d0, b + 1, ACT_WRITE, ST_OK);
      if (ok1) add_cmd(d1, b + 1, ACT_WRITE, ST_OK);
      if (!ok0 && !ok1) add_cmd(0, 0, ACT_NONE, ST_NO_DISK);
      return;
    end
    t = r1 ? turn_r1_m[pair] : turn_r01_m[pair];
    if (ok0 && ok1) d = t ? d0 : d1;
    else if (ok0) d = d0;
    else if (ok1) d = d1;
    else begin
      add_cmd(0, 0, ACT_NONE, ST_NO_DISK);
      return;
    end
    add_cmd(d, b + 1, ACT_READ, ST_OK);
    if (r1) turn_r1_m[pair] = (d != d0);
    else turn_r01_m[pair] = (d != d0);
  endfunction

  function automatic void parity_plan(bit wr, int nd, int tgt, int par, longint unsigned b);
    bit first;
    first = 1'b1;
    if (disk_ok(tgt)) begin
      if (wr) begin
        if (disk_ok(par)) begin
          add_cmd(tgt, b + 1, ACT_ACC_XOR, ST_OK);
          add_cmd(par, b + 1, ACT_ACC_XOR, ST_OK);
          add_cmd(par, b + 1, ACT_WRITE_ACC, ST_OK);
        end
        add_cmd(tgt, b + 1, ACT_WRITE, ST_OK);
      end else begin
        add_cmd(tgt, b + 1, ACT_READ, ST_OK);
      end
      return;
    end
    if (!rest_ok(nd, tgt)) begin
      add_cmd(0, 0, ACT_NONE, ST_NO_DISK);
      return;
    end
    for (int i = 0; i < nd; i++) begin
      if (i == tgt || (wr && i == par)) continue;
      if (wr) add_cmd(i, b + 1, ACT_ACC_XOR, ST_OK);
      else add_cmd(i, b + 1, first ? ACT_READ : ACT_READ_XOR, ST_OK);
      first = 1'b0;
    end
    if (wr) add_cmd(par, b + 1, ACT_WRITE_ACC, ST_OK);
  endfunction

  function automatic longint unsigned capacity();
    int nd;
    longint unsigned per;
    nd = clamp_disks();
    per = (bpd_m >= 2) ? longint'(bpd_m) - 1 : 0;
    case (lvl_m)
      LVL_R0: return nd * per;
      LVL_R1, LVL_R01: return (nd / 2) * per;
      default: return (nd >= 2) ? (nd - 1) * per : 0;
    endcase
  endfunction

  function automatic void map_access(bit wr, longint unsigned lb);
    int nd, half, tgt, par, pair;
    longint unsigned per, b;
    nd = clamp_disks();
    half = nd / 2;
    per = (bpd_m >= 2) ? longint'(bpd_m) - 1 : 0;
    if (lvl_m > LVL_R5) begin
      add_cmd(0, 0, ACT_NONE, ST_NO_DISK);
      return;
    end
    if (lb >= capacity()) begin
      add_cmd(0, 0, ACT_NONE, ST_RANGE);
      return;
    end
    if (lvl_m == LVL_R0) begin
      tgt = int'(lb % nd);
      b = lb / nd;
      if (!disk_ok(tgt)) add_cmd(0, 0, ACT_NONE, ST_NO_DISK);
      else add_cmd(tgt, b + 1, wr ? ACT_WRITE : ACT_READ, ST_OK);
    end else if (lvl_m == LVL_R1 || lvl_m == LVL_R01) begin
      if (lvl_m == LVL_R1) begin
        pair = int'(lb / per);
        b = lb % per;
      end else begin
        pair = int'(lb % half);
        b = lb / half;
      end
      if (pair >= PAIRS) add_cmd(0, 0, ACT_NONE, ST_RANGE);
      else mirror_plan(wr, pair, pair + half, b, lvl_m == LVL_R1, pair);
    end else begin
      tgt = int'(lb % (nd - 1));
      b = lb / (nd - 1);
      if (lvl_m == LVL_R4) begin
        par = nd - 1;
      end else begin
        par = nd - 1 - int'(b % nd);
        if (par <= tgt) tgt++;
      end
      parity_plan(wr, nd, tgt, par, b);
    end
  endfunction

  function automatic void predict_commands(req_t r);
    plan_q.delete();
    if (r.op == OP_READ || r.op == OP_WRITE) begin
      map_access(r.op == OP_WRITE, r.lb);
    end else if (r.op == OP_HEALTH) begin
      if (r.tm < clamp_disks()) begin
        health_m[r.tm] = (r.nh == HEALTH_BAD3) ? HEALTH_UNREC : r.nh;
        add_cmd(0, 0, ACT_NONE, ST_OK);
      end else begin
        add_cmd(0, 0, ACT_NONE, ST_RANGE);
      end
    end else begin
      add_cmd(0, 0, ACT_NONE, ST_OK);
    end
    plan_q[plan_q.size() - 1].last = 1'b1;
    foreach (plan_q[i]) cmd_q.push_back(plan_q[i]);
  endfunction

  // driver: hold a beat until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (issued == accepted) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur_req = req_q.pop_front();
        in_if.opcode <= cur_req.op;
        in_if.logical_block <= cur_req.lb;
        in_if.target_member <= cur_req.tm;
        in_if.new_health <= cur_req.nh;
        in_if.valid <= 1'b1;
        issued++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    disk_cmd_t e;
    if (rst_n) begin
      quiet_cycles++;
      if (in_if.valid && in_if.ready) begin
        predict_commands(cur_req);
        accepted++;
        quiet_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        if (cmd_q.size() == 0) begin
          $error("unexpected command beat: disk %0d block %0h", out_if.member_disk,
                 out_if.member_block);
          errors++;
        end else begin
          e = cmd_q.pop_front();
          if (out_if.member_disk !== e.disk) begin
            $error("member_disk exp %0d got %0d", e.disk, out_if.member_disk);
            errors++;
          end
          if (out_if.member_block !== e.blk) begin
            $error("member_block exp %0h got %0h", e.blk, out_if.member_block);
            errors++;
          end
          if (out_if.action !== e.act) begin
            $error("action exp %0d got %0d", e.act, out_if.action);
            errors++;
          end
          if (out_if.status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_if.status);
            errors++;
          end
          if (out_if.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_if.last);
            errors++;
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_req(logic [1:0] op, logic [31:0] lb, logic [2:0] tm, logic [1:0] nh);
    req_t r;
    r.op = op;
    r.lb = lb;
    r.tm = tm;
    r.nh = nh;
    req_q.push_back(r);
  endtask

  task automatic drain();
    wait (req_q.size() == 0 && issued == accepted && cmd_q.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RAID_LEVEL: lvl_m = val[2:0];
      CFG_DISKS: disks_m = val[3:0];
      default: bpd_m = val;
    endcase
  endtask

  task automatic set_array(logic [2:0] lvl, logic [3:0] nd, logic [31:0] bpd);
    drain();
    write_reg(CFG_RAID_LEVEL, 32'(lvl));
    write_reg(CFG_DISKS, 32'(nd));
    write_reg(CFG_BPD, bpd);
    // send a heal request for every disk slot; slots past the disk count answer out of range
    for (int i = 0; i < MAX_DISKS; i++) push_req(OP_HEALTH, '0, i[2:0], HEALTH_OK);
  endtask

  task automatic random_reqs(int n);
    longint unsigned cap;
    logic [31:0] lb;
    int k;
    cap = capacity();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 10) begin
        push_req(OP_HEALTH, $urandom, 3'($urandom_range(7)),
                 ($urandom_range(2) == 0) ? 2'($urandom) : HEALTH_OK);
      end else if (k < 13) begin
        push_req(2'd3, $urandom, 3'($urandom), 2'($urandom));
      end else begin
        k = $urandom_range(99);
        if (cap > 0 && k < 75) lb = 32'({$urandom, $urandom} % cap);
        else if (cap > 0 && k < 85) lb = 32'(cap - 1 + $urandom_range(1));
        else lb = $urandom;
        push_req(2'($urandom_range(1)), lb, 3'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.logical_block = '0;
    in_if.target_member = '0;
    in_if.new_health = '0;
    out_if.ready = 1'b0;
    lvl_m = LVL_R0;
    disks_m = ND_RESET;
    bpd_m = BPD_RESET;
    for (int i = 0; i < MAX_DISKS; i++) health_m[i] = HEALTH_OK;
    for (int i = 0; i < PAIRS; i++) begin
      turn_r1_m[i] = 1'b0;
      turn_r01_m[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 31;
    recv_idle = 70;

    // directed, reset configuration (RAID0, 8 disks)
    push_req(OP_READ, 32'd0, 3'd0, 2'd0);
    push_req(OP_WRITE, 32'd524279, 3'd7, 2'd3);
    push_req(OP_READ, 32'd524280, 3'd0, 2'd0);
    push_req(OP_WRITE, 32'hFFFF_FFFF, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd3, 2'd1);
    push_req(OP_READ, 32'd3, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd3, HEALTH_BAD3);
    push_req(OP_WRITE, 32'd11, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd3, HEALTH_OK);
    push_req(2'd3, 32'hFFFF_FFFF, 3'd7, 2'd3);
    push_req(OP_WRITE, 32'd11, 3'd0, 2'd0);

    // RAID5 small disks: degraded read and write, rotating parity
    set_array(LVL_R5, 4'd4, 32'd5);
    for (int i = 0; i < 4; i++) push_req(OP_READ, 32'(i), 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd1, 2'd2);
    push_req(OP_READ, 32'd1, 3'd0, 2'd0);
    push_req(OP_WRITE, 32'd1, 3'd0, 2'd0);
    push_req(OP_WRITE, 32'd0, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd2, 2'd1);
    push_req(OP_READ, 32'd1, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd6, 2'd0);
    // hold off until the block has answered everything
    wait (req_q.size() == 0 && issued == accepted && cmd_q.size() == 0);
    random_reqs(25);

    set_array(LVL_R1, 4'd8, 32'd3);
    push_req(OP_READ, 32'd0, 3'd0, 2'd0);
    push_req(OP_READ, 32'd0, 3'd0, 2'd0);
    push_req(OP_HEALTH, '0, 3'd0, 2'd1);
    push_req(OP_HEALTH, '0, 3'd4, 2'd1);
    push_req(OP_READ, 32'd1, 3'd0, 2'd0);
    push_req(OP_WRITE, 32'd1, 3'd0, 2'd0);
    random_reqs(20);
    set_array(LVL_R01, 4'd8, 32'd4);
    random_reqs(20);
    set_array(LVL_R4, 4'd5, 32'd6);
    random_reqs(20);

    send_idle = 70;
    recv_idle = 31;
    set_array(LVL_R5, 4'd8, 32'd4);
    random_reqs(20);
    set_array(LVL_R0, 4'd15, 32'hFFFF_FFFF);
    random_reqs(25);
    set_array(LVL_R5, 4'd3, 32'hFFFF_FFFF);
    random_reqs(25);
    set_array(LVL_R1, 4'd1, 32'd2);
    random_reqs(8);
    set_array(3'd7, 4'd0, 32'd0);
    random_reqs(8);

    send_idle = 0;
    recv_idle = 0;
    set_array(LVL_R4, 4'd2, 32'd1);
    random_reqs(8);
    set_array(LVL_R01, 4'd6, 32'd9);
    random_reqs(15);
    set_array(LVL_R5, 4'd5, 32'd7);
    random_reqs(20);
    set_array(LVL_R4, 4'd8, 32'd2);
    random_reqs(15);

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rbap_pkg.sv
rtl/rbap_chan_if.sv
rtl/rbap_div.sv
rtl/rbap_dp.sv
rtl/rbap_ctrl.sv
rtl/raid_block_access_planner.sv
test/tb_raid_block_access_planner.sv
